// ===== rtl/pulse_width_sensor_packet_transmitter_unit_macros.svh =====
// assertion macros shared by the pulse width sensor transmitter rtl
// expects clk_i and rst_ni in the scope of the module that uses them
`ifndef PULSE_WIDTH_SENSOR_PACKET_TRANSMITTER_UNIT_MACROS_SVH
`define PULSE_WIDTH_SENSOR_PACKET_TRANSMITTER_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define PWSPTU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define PWSPTU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/pwsptu_pkg.sv =====
// shared types and constants of the pulse width sensor packet transmitter
// no dependencies
`default_nettype none

package pwsptu_pkg;

  // default frame shape
  localparam int PreambleLenDef = 8;
  localparam int PayloadLenDef  = 41;

  // register widths and reset values
  localparam int TicksW   = 16;
  localparam int RepeatW  = 8;
  localparam int BitIdxW  = 8;
  localparam int PacketW  = 48;

  localparam logic [TicksW-1:0]  BitPeriodRst = 16'd6000;
  localparam logic [TicksW-1:0]  ShortHighRst = 16'd2000;
  localparam logic [TicksW-1:0]  LongHighRst  = 16'd4000;
  localparam logic [RepeatW-1:0] RepeatRst    = 8'd15;

  // register map
  typedef enum logic [1:0] {
    REG_BIT_PERIOD = 2'd0,
    REG_SHORT_HIGH = 2'd1,
    REG_LONG_HIGH  = 2'd2,
    REG_REPEAT     = 2'd3
  } cfg_reg_e;

  // request opcodes
  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_START = 1'b1
  } opcode_e;

  // reading limits
  localparam logic signed [11:0] TempMin = -12'sd677;
  localparam logic signed [11:0] TempMax = 12'sd1590;
  localparam logic [7:0]         HumMax  = 8'd100;

  // fahrenheit offset 320 plus raw offset 900
  localparam logic signed [12:0] RawOffset = 13'sd1220;
  // ceil(2^18 / 5), exact for magnitudes up to 14310
  localparam logic [15:0]        RecipFive = 16'd52429;
  localparam int                 RecipShift = 18;

endpackage

`default_nettype wire

// ===== rtl/pulse_width_sensor_packet_transmitter_unit.sv =====
// top level of the pulse width sensor packet transmitter
// depends on pwsptu_pkg and pulse_width_sensor_packet_transmitter_unit_macros.svh
//
//   channel  direction  handshake               payload
//   in       sink       in_valid_i / in_ready_o  opcode, reading fields
//   out      source     out_valid_o / out_ready_i line_level, busy_res, rejected, packet_done
//   cfg      sink       cfg_we_i (no wait)       cfg_idx_i, cfg_wdata_i
//
// one request per clock while no result is held by out_ready_i low: each request is
// folded into the state registers and the result register in the cycle it is accepted
// the path is set by the temperature conversion (one 15x16 multiply) feeding
// the checksum add, and by the tick compare and bit select of the sequencer
// in_ready_o drops only while a result is held by out_ready_i low
// reset: line low, idle, registers at their documented defaults
`default_nettype none

`include "pulse_width_sensor_packet_transmitter_unit_macros.svh"

module pulse_width_sensor_packet_transmitter_unit
  import pwsptu_pkg::*;
#(
  parameter int PREAMBLE_LEN = PreambleLenDef,
  parameter int PAYLOAD_LEN  = PayloadLenDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // configuration
  input  wire logic              cfg_we_i,
  input  wire logic [1:0]        cfg_idx_i,
  input  wire logic [15:0]       cfg_wdata_i,
  // request channel
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic              opcode_i,
  input  wire logic [7:0]        sensor_id_i,
  input  wire logic              battery_low_i,
  input  wire logic              test_flag_i,
  input  wire logic [1:0]        channel_i,
  input  wire logic signed [11:0] temperature_i,
  input  wire logic [7:0]        humidity_i,
  // result channel
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic                   line_level_o,
  output logic                   busy_res_o,
  output logic                   rejected_o,
  output logic                   packet_done_o
);

  // last preamble index and last data index
  localparam logic [BitIdxW-1:0] PreIdx  = BitIdxW'(PREAMBLE_LEN);
  localparam logic [BitIdxW-1:0] LastIdx = BitIdxW'(PREAMBLE_LEN + PAYLOAD_LEN);

  // configuration registers
  logic [TicksW-1:0]  period_q, short_q, long_q;
  logic [RepeatW-1:0] rep_cnt_q;

  // sequencer state
  logic [PacketW-1:0] packet_q, packet_d;
  logic [BitIdxW-1:0] bit_idx_q, bit_idx_d;
  logic [TicksW-1:0]  tick_q, tick_d;
  logic [TicksW-1:0]  high_q, high_d;
  logic [RepeatW-1:0] reps_q, reps_d;
  logic               line_q, line_d;
  logic               active_q, active_d;

  // result register
  logic out_valid_q, out_valid_d;
  logic rej_q, rej_d;
  logic done_q, done_d;

  logic in_acc;

  // ---------------------------------------------------------------------------
  // configuration writes
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q  <= BitPeriodRst;
      short_q   <= ShortHighRst;
      long_q    <= LongHighRst;
      rep_cnt_q <= RepeatRst;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_BIT_PERIOD: period_q  <= cfg_wdata_i;
        REG_SHORT_HIGH: short_q   <= cfg_wdata_i;
        REG_LONG_HIGH:  long_q    <= cfg_wdata_i;
        REG_REPEAT:     rep_cnt_q <= cfg_wdata_i[RepeatW-1:0];
        default:        ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // reading check and packet build
  // ---------------------------------------------------------------------------
  logic               temp_neg;
  logic [10:0]        temp_mag;
  logic [14:0]        temp_x9;
  logic [30:0]        div_prod;
  logic [12:0]        div_q;
  logic signed [12:0] fahr;
  logic [12:0]        raw13;
  logic [11:0]        raw;
  logic [7:0]         byte1, byte2, csum;
  logic               reading_ok;

  always_comb begin
    // truncating (x * 18) / 10 as sign * (|x| * 9) / 5
    temp_neg = temperature_i[11];
    temp_mag = temp_neg ? 11'(-temperature_i) : temperature_i[10:0];
    temp_x9  = {1'b0, temp_mag, 3'b000} + {4'b0000, temp_mag};
    div_prod = {1'b0, temp_x9} * {15'd0, RecipFive};
    div_q    = div_prod[RecipShift +: 13];
    fahr     = temp_neg ? -$signed(div_q) : $signed(div_q);
    raw13    = 13'(fahr + RawOffset);
    raw      = raw13[11:0];

    byte1 = {battery_low_i, test_flag_i, channel_i, raw[11:8]};
    byte2 = raw[7:0];
    csum  = sensor_id_i + byte1 + byte2 + humidity_i;

    reading_ok = (channel_i != 2'd0) && (humidity_i <= HumMax) &&
                 (temperature_i >= TempMin) && (temperature_i <= TempMax);
  end

  // ---------------------------------------------------------------------------
  // tick sequencer: lead low, preamble half cycles, then data bits msb first
  // ---------------------------------------------------------------------------
  logic [TicksW-1:0]  tick_inc;
  logic               in_data;
  logic               tick_done;
  logic [BitIdxW-1:0] next_idx;
  logic [5:0]         data_pos, data_sh;
  logic               data_bit;
  logic [TicksW-1:0]  high_sel;

  always_comb begin
    tick_inc  = tick_q + 1'b1;
    in_data   = bit_idx_q > PreIdx;
    tick_done = in_data && (tick_inc >= high_q) && (bit_idx_q >= LastIdx);

    // bit select for the segment that the next index enters
    next_idx = bit_idx_q + 1'b1;
    data_pos = 6'(next_idx - PreIdx - 1'b1);
    data_sh  = 6'd47 - data_pos;
    data_bit = (data_sh < 6'(PacketW)) ? packet_q[data_sh] : 1'b0;
    high_sel = data_bit ? long_q : short_q;
    if (high_sel > period_q) begin
      high_sel = period_q;
    end
  end

  always_comb begin
    packet_d  = packet_q;
    bit_idx_d = bit_idx_q;
    tick_d    = tick_q;
    high_d    = high_q;
    reps_d    = reps_q;
    line_d    = line_q;
    active_d  = active_q;
    rej_d     = 1'b0;
    done_d    = 1'b0;

    if (opcode_e'(opcode_i) == OP_START) begin
      if (active_q || !reading_ok) begin
        rej_d = 1'b1;
      end else begin
        packet_d  = {sensor_id_i, byte1, byte2, humidity_i, csum, 8'h00};
        reps_d    = (rep_cnt_q != '0) ? rep_cnt_q : RepeatW'(1);
        active_d  = 1'b1;
        bit_idx_d = '0;
        tick_d    = '0;
        high_d    = '0;
        line_d    = 1'b0;
      end
    end else if (active_q) begin
      tick_d = tick_inc;
      if (in_data && tick_inc >= high_q) begin
        line_d = 1'b0;
      end
      if (!tick_done && tick_inc >= period_q) begin
        // next segment
        bit_idx_d = next_idx;
        tick_d    = '0;
        if (next_idx <= PreIdx) begin
          line_d = next_idx[0];
          high_d = '0;
        end else begin
          line_d = 1'b1;
          high_d = high_sel;
        end
      end
      if (tick_done) begin
        // packet finished: restart the send or end the run
        done_d    = 1'b1;
        reps_d    = reps_q - 1'b1;
        active_d  = (reps_q != RepeatW'(1));
        bit_idx_d = '0;
        tick_d    = '0;
        high_d    = '0;
        line_d    = 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // handshake and registers
  // ---------------------------------------------------------------------------
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_d = in_acc || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_idx_q   <= '0;
      tick_q      <= '0;
      high_q      <= '0;
      reps_q      <= '0;
      line_q      <= 1'b0;
      active_q    <= 1'b0;
      packet_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_acc) begin
        bit_idx_q <= bit_idx_d;
        tick_q    <= tick_d;
        high_q    <= high_d;
        reps_q    <= reps_d;
        line_q    <= line_d;
        active_q  <= active_d;
        packet_q  <= packet_d;
      end
    end
  end

  // per-request flags, held while the result waits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rej_q  <= 1'b0;
      done_q <= 1'b0;
    end else if (in_acc) begin
      rej_q  <= rej_d;
      done_q <= done_d;
    end
  end

  // line and busy only change on an accepted request, so they double as result fields
  assign out_valid_o   = out_valid_q;
  assign line_level_o  = line_q;
  assign busy_res_o    = active_q;
  assign rejected_o    = rej_q;
  assign packet_done_o = done_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  `PWSPTU_ASSERT_NOW(a_idle_line_low, !active_q, !line_q, "line high while idle")
  `PWSPTU_ASSERT_NOW(a_active_reps, active_q, reps_q != '0, "run active with no repeats left")
  `PWSPTU_ASSERT_NOW(a_no_overwrite, out_valid_q && !out_ready_i, !in_acc,
                     "request taken while result stalled")
  `PWSPTU_ASSERT_NEXT(a_state_hold, !in_acc, $stable(bit_idx_q) && $stable(tick_q),
                      "sequencer moved without a request")
  `PWSPTU_ASSERT_NEXT(a_last_done,
                      in_acc && (opcode_e'(opcode_i) == OP_TICK) && tick_done &&
                      reps_q == RepeatW'(1),
                      !active_q && packet_done_o, "run did not end after last packet")

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// self-checking bench for the pulse width sensor packet transmitter unit
// drives reading and tick requests under random idling and checks every result
// depends on pwsptu_pkg and the rtl top level only
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pwsptu_pkg::*;

  // one request as it goes out on the request channel
  typedef struct packed {
    opcode_e            op;
    logic [7:0]         id;
    logic               batt;
    logic               test;
    logic [1:0]         chan;
    logic signed [11:0] temp;
    logic [7:0]         hum;
  } reading_t;

  // one result: line level, busy, rejected, packet done
  typedef struct packed {
    logic line;
    logic busy;
    logic rej;
    logic done;
  } line_res_t;

  // directed step: a register write or a request, with an optional typed result
  typedef struct packed {
    logic        is_write;
    cfg_reg_e    sel;
    logic [15:0] wval;
    reading_t    rd;
    logic        fixed;
    line_res_t   want;
  } script_row_t;

  localparam int          SCRIPT_LEN     = 28;
  localparam int          PHASES         = 10;
  localparam int          RAND_PER_PHASE = 190;
  localparam int unsigned CYCLE_LIMIT    = 200_000;

  // payload fields are ignored on ticks, so give them a busy pattern
  localparam reading_t TickRd = '{OP_TICK, 8'hA5, 1'b1, 1'b0, 2'd2, -12'sd1, 8'hC3};

  // dut side signals
  logic               clk_i;
  logic               rst_ni        = 1'b0;
  logic               cfg_we_i      = 1'b0;
  logic [1:0]         cfg_idx_i     = REG_BIT_PERIOD;
  logic [15:0]        cfg_wdata_i   = 16'd0;
  logic               in_valid_i    = 1'b0;
  logic               in_ready_o;
  logic               opcode_i      = OP_TICK;
  logic [7:0]         sensor_id_i   = 8'd0;
  logic               battery_low_i = 1'b0;
  logic               test_flag_i   = 1'b0;
  logic [1:0]         channel_i     = 2'd0;
  logic signed [11:0] temperature_i = 12'sd0;
  logic [7:0]         humidity_i    = 8'd0;
  logic               out_valid_o;
  logic               out_ready_i   = 1'b0;
  logic               line_level_o;
  logic               busy_res_o;
  logic               rejected_o;
  logic               packet_done_o;

  // predicted register contents
  logic [15:0] period_ticks;
  logic [15:0] zero_high;
  logic [15:0] one_high;
  logic [7:0]  sends_per_start;

  // predicted sequencer state
  logic [47:0] pkt_bits;
  logic [7:0]  seg_cnt;      // 0 lead low, then preamble halves, then data bits
  logic [15:0] seg_ticks;
  logic [15:0] hold_high;
  logic [7:0]  sends_left;
  logic        line_now;
  logic        run_on;

  // results still owed by the dut, oldest first
  line_res_t   line_status_q [$];
  int          err_cnt = 0;
  int unsigned cycle_cnt;
  bit          in_calm = 1'b0;

  // directed table
  // want column reads line, busy, rejected, done
  script_row_t script_rows [SCRIPT_LEN] = '{
    // tick while idle: line stays low
    '{1'b0, REG_BIT_PERIOD, 16'd0, TickRd, 1'b1, 4'b0000},
    // invalid readings are refused while idle
    '{1'b0, REG_BIT_PERIOD, 16'd0, '{OP_START, 8'h12, 1'b0, 1'b0, 2'd0, 12'sd200, 8'd50},
      1'b1, 4'b0010},
    '{1'b0, REG_BIT_PERIOD, 16'd0, '{OP_START, 8'h34, 1'b0, 1'b1, 2'd1, 12'sd200, 8'd101},
      1'b1, 4'b0010},
    '{1'b0, REG_BIT_PERIOD, 16'd0, '{OP_START, 8'h56, 1'b1, 1'b0, 2'd2, -12'sd678, 8'd40},
      1'b1, 4'b0010},
    '{1'b0, REG_BIT_PERIOD, 16'd0, '{OP_START, 8'h78, 1'b0, 1'b0, 2'd3, 12'sd1591, 8'd60},
      1'b1, 4'b0010},
    '{1'b0, REG_BIT_PERIOD, 16'd0, '{OP_START, 8'h9A, 1'b1, 1'b1, 2'd1, -12'sd2048, 8'd255},
      1'b1, 4'b0010},
    '{1'b0, REG_BIT_PERIOD, 16'd0, '{OP_START, 8'hBC, 1'b0, 1'b1, 2'd2, 12'sd2047, 8'd0},
      1'b1, 4'b0010},
    // repeat count zero acts as one, upper data byte is don't care
    '{1'b1, REG_REPEAT, 16'hAB00, TickRd, 1'b0, 4'b0000},
    // valid reading at the top of every range starts a run
    '{1'b0, REG_BIT_PERIOD, 16'd0, '{OP_START, 8'hFF, 1'b1, 1'b1, 2'd3, 12'sd1590, 8'd100},
      1'b1, 4'b0100},
    // start while busy is refused even with a valid reading
    '{1'b0, REG_BIT_PERIOD, 16'd0, '{OP_START, 8'h00, 1'b0, 1'b0, 2'd1, -12'sd677, 8'd0},
      1'b1, 4'b0110},
    '{1'b0, REG_BIT_PERIOD, 16'd0, TickRd, 1'b0, 4'b0000},
    // period changes mid run take effect at once
    '{1'b1, REG_BIT_PERIOD, 16'hFFFF, TickRd, 1'b0, 4'b0000},
    '{1'b0, REG_BIT_PERIOD, 16'd0, TickRd, 1'b0, 4'b0000},
    '{1'b0, REG_BIT_PERIOD, 16'd0, TickRd, 1'b0, 4'b0000},
    // period zero: every segment is one tick
    '{1'b1, REG_BIT_PERIOD, 16'd0, TickRd, 1'b0, 4'b0000},
    '{1'b0, REG_BIT_PERIOD, 16'd0, TickRd, 1'b0, 4'b0000},
    '{1'b0, REG_BIT_PERIOD, 16'd0, TickRd, 1'b0, 4'b0000},
    '{1'b0, REG_BIT_PERIOD, 16'd0, TickRd, 1'b0, 4'b0000},
    '{1'b0, REG_BIT_PERIOD, 16'd0, TickRd, 1'b0, 4'b0000},
    // high times above the period get clipped
    '{1'b1, REG_BIT_PERIOD, 16'd2, TickRd, 1'b0, 4'b0000},
    '{1'b1, REG_SHORT_HIGH, 16'hFFFF, TickRd, 1'b0, 4'b0000},
    '{1'b1, REG_LONG_HIGH, 16'd0, TickRd, 1'b0, 4'b0000},
    '{1'b0, REG_BIT_PERIOD, 16'd0, TickRd, 1'b0, 4'b0000},
    '{1'b0, REG_BIT_PERIOD, 16'd0, TickRd, 1'b0, 4'b0000},
    '{1'b0, REG_BIT_PERIOD, 16'd0, TickRd, 1'b0, 4'b0000},
    '{1'b0, REG_BIT_PERIOD, 16'd0, TickRd, 1'b0, 4'b0000},
    '{1'b0, REG_BIT_PERIOD, 16'd0, TickRd, 1'b0, 4'b0000},
    '{1'b0, REG_BIT_PERIOD, 16'd0, TickRd, 1'b0, 4'b0000}
  };

  pulse_width_sensor_packet_transmitter_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .opcode_i      (opcode_i),
    .sensor_id_i   (sensor_id_i),
    .battery_low_i (battery_low_i),
    .test_flag_i   (test_flag_i),
    .channel_i     (channel_i),
    .temperature_i (temperature_i),
    .humidity_i    (humidity_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .line_level_o  (line_level_o),
    .busy_res_o    (busy_res_o),
    .rejected_o    (rejected_o),
    .packet_done_o (packet_done_o)
  );

  // 50 MHz
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // hard stop in case the handshake hangs
  initial begin : watchdog
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // back to lead low of a fresh send
  function automatic void restart_send();
    seg_cnt   = '0;
    seg_ticks = '0;
    hold_high = '0;
    line_now  = 1'b0;
  endfunction

  // fold one accepted request into the predicted state, return the line status after it
  function automatic line_res_t advance_transmitter(reading_t rd);
    line_res_t   res;
    int          temp_c;
    int          raw_full;
    int          bit_pos;
    logic [7:0]  b_flags;
    logic [7:0]  b_low;
    logic [7:0]  b_sum;
    logic [15:0] hi;
    logic        in_data;
    res = '0;
    if (rd.op == OP_START) begin
      temp_c = int'($signed(rd.temp));
      if (run_on || rd.chan == 2'd0 || rd.hum > HumMax ||
          temp_c < TempMin || temp_c > TempMax) begin
        // refused: state untouched, no time passes
        res.rej = 1'b1;
      end else begin
        // tenths fahrenheit plus 900, division truncates toward zero
        raw_full   = (temp_c * 18) / 10 + 320 + 900;
        b_flags    = {rd.batt, rd.test, rd.chan, raw_full[11:8]};
        b_low      = raw_full[7:0];
        b_sum      = rd.id + b_flags + b_low + rd.hum;
        pkt_bits   = {rd.id, b_flags, b_low, rd.hum, b_sum, 8'h00};
        sends_left = (sends_per_start != 8'd0) ? sends_per_start : 8'd1;
        run_on     = 1'b1;
        restart_send();
      end
    end else if (run_on) begin
      in_data   = seg_cnt > PreambleLenDef;
      seg_ticks = seg_ticks + 16'd1;
      if (in_data && seg_ticks >= hold_high) begin
        line_now = 1'b0;
        // the send ends once the last data bit has had its high time
        if (seg_cnt >= PreambleLenDef + PayloadLenDef) res.done = 1'b1;
      end
      if (!res.done && seg_ticks >= period_ticks) begin
        seg_cnt   = seg_cnt + 8'd1;
        seg_ticks = '0;
        if (seg_cnt <= PreambleLenDef) begin
          // lead low then alternating preamble, high first
          line_now  = seg_cnt[0];
          hold_high = '0;
        end else begin
          // data bit msb first, high time latched here and clipped to the period
          // positions past the packet wrap in six bits and read as zero
          bit_pos   = (47 - ((int'(seg_cnt) - PreambleLenDef - 1) & 63)) & 63;
          hi        = ((bit_pos < 48) ? pkt_bits[bit_pos] : 1'b0) ? one_high : zero_high;
          hold_high = (hi > period_ticks) ? period_ticks : hi;
          line_now  = 1'b1;
        end
      end
      if (res.done) begin
        sends_left = sends_left - 8'd1;
        if (sends_left == 8'd0) run_on = 1'b0;
        restart_send();
      end
    end
    res.line = line_now;
    res.busy = run_on;
    return res;
  endfunction

  // present one request after a random gap and hold it until taken
  task automatic offer_reading(reading_t rd);
    int gap;
    if ($urandom_range(0, 39) == 0) in_calm = !in_calm;
    gap = in_calm ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    opcode_i      <= rd.op;
    sensor_id_i   <= rd.id;
    battery_low_i <= rd.batt;
    test_flag_i   <= rd.test;
    channel_i     <= rd.chan;
    temperature_i <= rd.temp;
    humidity_i    <= rd.hum;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
  endtask

  // quiet the request channel and let every owed result come back
  task automatic settle();
    in_valid_i <= 1'b0;
    while (line_status_q.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  // write enable stays high, the caller drops it after the last write
  task automatic write_reg(cfg_reg_e sel, logic [15:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= sel;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (sel)
      REG_BIT_PERIOD: period_ticks = val;
      REG_SHORT_HIGH: zero_high = val;
      REG_LONG_HIGH:  one_high = val;
      REG_REPEAT:     sends_per_start = val[7:0];
      default: ;
    endcase
  endtask

  task automatic check_field(string what, logic want_b, logic got_b);
    if (got_b !== want_b) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %0b got %0b", $time, what, want_b, got_b);
    end
  endtask

  // result side: random stalls, compare against the oldest owed result
  initial begin : result_check
    line_res_t want;
    line_res_t got;
    int        stall;
    bit        out_calm;
    out_calm = 1'b0;
    wait (rst_ni);
    forever begin
      if ($urandom_range(0, 39) == 0) out_calm = !out_calm;
      stall = out_calm ? 0 : $urandom_range(0, 4);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      got = '{line_level_o, busy_res_o, rejected_o, packet_done_o};
      if (line_status_q.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected result, expected none got line %0b busy %0b rej %0b done %0b",
                 $time, got.line, got.busy, got.rej, got.done);
      end else begin
        want = line_status_q.pop_front();
        check_field("line_level", want.line, got.line);
        check_field("busy_res", want.busy, got.busy);
        check_field("rejected", want.rej, got.rej);
        check_field("packet_done", want.done, got.done);
      end
    end
  end

  // stimulus: reset, directed table, then random phases
  initial begin : stimulus
    reading_t    rd;
    line_res_t   pred;
    logic [15:0] per;
    logic [15:0] zh;
    logic [15:0] oh;
    logic [7:0]  reps;
    logic [7:0]  junk;
    int          kind;
    int          t;
    bit          we_open;

    // predictor at its reset values
    period_ticks    = BitPeriodRst;
    zero_high       = ShortHighRst;
    one_high        = LongHighRst;
    sends_per_start = RepeatRst;
    pkt_bits        = '0;
    sends_left      = '0;
    run_on          = 1'b0;
    restart_send();
    we_open         = 1'b0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed part, writes only with nothing in flight
    for (int i = 0; i < SCRIPT_LEN; i++) begin
      if (script_rows[i].is_write) begin
        if (!we_open) settle();
        write_reg(script_rows[i].sel, script_rows[i].wval);
        we_open = 1'b1;
      end else begin
        if (we_open) cfg_we_i <= 1'b0;
        we_open = 1'b0;
        offer_reading(script_rows[i].rd);
        pred = advance_transmitter(script_rows[i].rd);
        line_status_q.push_back(script_rows[i].fixed ? script_rows[i].want : pred);
      end
    end

    // random phases, each with its own register setting
    // a run may still be going when the next setting lands
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          // period zero and repeat zero
          per = 16'd0; zh = 16'd0; oh = 16'd0; reps = 8'd0;
        end
        1: begin
          per = 16'd1; zh = 16'd1; oh = 16'hFFFF; reps = 8'd1;
        end
        2: begin
          per = 16'd3; zh = 16'hFFFF; oh = 16'd2; reps = 8'd2;
        end
        PHASES - 1: begin
          // largest repeat count, short segments so many packets get out
          per  = 16'($urandom_range(0, 1));
          zh   = 16'($urandom_range(0, 2));
          oh   = 16'($urandom_range(0, 2));
          reps = 8'd255;
        end
        default: begin
          per  = 16'($urandom_range(1, 4));
          zh   = 16'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                 : $urandom_range(0, per + 1));
          oh   = 16'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                 : $urandom_range(0, per + 1));
          reps = 8'($urandom_range(0, 3));
        end
      endcase
      junk = 8'($urandom_range(0, 255));
      settle();
      write_reg(REG_BIT_PERIOD, per);
      write_reg(REG_SHORT_HIGH, zh);
      write_reg(REG_LONG_HIGH, oh);
      write_reg(REG_REPEAT, {junk, reps});
      cfg_we_i <= 1'b0;

      repeat (RAND_PER_PHASE) begin
        // ticks carry random payload bits, the dut must ignore them
        rd.op   = OP_TICK;
        rd.id   = 8'($urandom_range(0, 255));
        rd.batt = 1'($urandom_range(0, 1));
        rd.test = 1'($urandom_range(0, 1));
        rd.chan = 2'($urandom_range(0, 3));
        rd.temp = 12'($urandom_range(0, 4095));
        rd.hum  = 8'($urandom_range(0, 255));
        // starts mostly while idle, now and then one that hits a busy run
        if (run_on ? ($urandom_range(0, 19) == 0) : ($urandom_range(0, 2) == 0)) begin
          rd.op = OP_START;
          kind  = $urandom_range(0, 15);
          if (kind < 15) begin
            // well-formed reading, range edges weighted up
            rd.chan = 2'($urandom_range(1, 3));
            rd.hum  = 8'($urandom_range(0, 100));
            case ($urandom_range(0, 9))
              0: rd.temp = TempMin;
              1: rd.temp = TempMax;
              default: begin
                t       = int'($urandom_range(0, 2267)) - 677;
                rd.temp = t[11:0];
              end
            endcase
          end
          // break one field just past its limit, or keep the raw random fields
          case (kind)
            12: rd.chan = 2'd0;
            13: rd.hum = HumMax + 8'd1;
            14: rd.temp = $urandom_range(0, 1) ? TempMin - 12'sd1 : TempMax + 12'sd1;
            default: ;
          endcase
        end
        offer_reading(rd);
        line_status_q.push_back(advance_transmitter(rd));
      end
    end

    settle();
    repeat (4) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
